### design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Holds the packet that travels from the decoder to the serializer, the
// error codes, the UTF-8 encoder and the hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Error codes reported on the result channel.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNTERM  = 2'd1;
  localparam logic [1:0] ERR_BAD_ESC = 2'd2;
  localparam logic [1:0] ERR_BAD_HEX = 2'd3;

  // Packets buffered between the decoder and the serializer.
  localparam int QUEUE_DEPTH = 2;

  // Most bytes that one text byte can produce.
  localparam int PKT_BYTES = 6;

  // One encoded code point, first byte in b[0].
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } enc_t;

  // Everything that one accepted text byte produces.
  typedef struct packed {
    logic [PKT_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      done;
    logic [1:0]                err;
  } pkt_t;

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.b[0] = cp[7:0];
      e.len  = 3'd1;
    end else if (cp < 21'h800) begin
      e.b[0] = 8'hC0 | {3'b000, cp[10:6]};
      e.b[1] = 8'h80 | {2'b00, cp[5:0]};
      e.len  = 3'd2;
    end else if (cp < 21'h10000) begin
      e.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
      e.b[1] = 8'h80 | {2'b00, cp[11:6]};
      e.b[2] = 8'h80 | {2'b00, cp[5:0]};
      e.len  = 3'd3;
    end else begin
      e.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
      e.b[1] = 8'h80 | {2'b00, cp[17:12]};
      e.b[2] = 8'h80 | {2'b00, cp[11:6]};
      e.b[3] = 8'h80 | {2'b00, cp[5:0]};
      e.len  = 3'd4;
    end
    return e;
  endfunction

  // Returns {valid, value} for an ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: byte decoder
// Runs the escape machine on one text byte per cycle unless q_full, and packs
// all bytes, the done flag or the error that the byte causes into one packet.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_text_byte,
  input  wire logic          in_opens_string,
  input  wire logic          in_end_of_text,
  input  wire logic          q_full,
  output logic               push,
  output jsu_pkg::pkt_t      pkt
);

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_BODY   = 3'd1;
  localparam logic [2:0] M_ESC    = 3'd2;
  localparam logic [2:0] M_HEX1   = 3'd3;
  localparam logic [2:0] M_HSWAIT = 3'd4;
  localparam logic [2:0] M_HSESC  = 3'd5;
  localparam logic [2:0] M_HEX2   = 3'd6;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] HI_SURR  = 16'hD800;
  localparam logic [15:0] LO_SURR  = 16'hDC00;
  localparam logic [15:0] SURR_END = 16'hE000;
  localparam logic [15:0] REPLACE  = 16'hFFFD;
  localparam logic [20:0] PLANE1   = 21'h10000;

  logic [2:0]  mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [15:0] hs_r, hs_nxt;

  logic             accept;
  logic             run_body;
  logic             run_esc;
  logic [2:0]       esc_hex_mode;
  logic             pre_en;
  logic [15:0]      pre_cp;
  jsu_pkg::enc_t    pre_e;
  jsu_pkg::enc_t    main_e;
  logic             done;
  logic [1:0]       err;
  logic [4:0]       hv;
  logic [15:0]      unit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mode_nxt     = mode_r;
    hex_cnt_nxt  = hex_cnt_r;
    accum_nxt    = accum_r;
    hs_nxt       = hs_r;
    run_body     = 1'b0;
    run_esc      = 1'b0;
    esc_hex_mode = M_HEX1;
    pre_en       = 1'b0;
    pre_cp       = hs_r;
    main_e       = '0;
    done         = 1'b0;
    err          = jsu_pkg::ERR_NONE;
    hv           = jsu_pkg::hex_digit(in_text_byte);
    unit         = {accum_r[11:0], hv[3:0]};

    if (in_opens_string) begin
      mode_nxt    = M_BODY;
      hex_cnt_nxt = '0;
      accum_nxt   = '0;
      hs_nxt      = '0;
    end else begin
      unique case (mode_r) inside
        M_BODY: begin
          run_body = 1'b1;
        end
        M_ESC: begin
          run_esc = 1'b1;
        end
        M_HEX1, M_HEX2: begin
          if (!hv[4]) begin
            err      = jsu_pkg::ERR_BAD_HEX;
            mode_nxt = M_IDLE;
          end else begin
            accum_nxt = unit;
            if (hex_cnt_r != 2'd3) begin
              hex_cnt_nxt = hex_cnt_r + 2'd1;
            end else begin
              hex_cnt_nxt = '0;
              mode_nxt    = M_BODY;
              if (mode_r == M_HEX1) begin
                if (unit >= HI_SURR && unit < LO_SURR) begin
                  hs_nxt   = unit;
                  mode_nxt = M_HSWAIT;
                end else begin
                  main_e = jsu_pkg::utf8_encode({5'b0, unit});
                end
              end else if (unit >= LO_SURR && unit < SURR_END) begin
                main_e = jsu_pkg::utf8_encode(PLANE1 + {1'b0, hs_r[9:0], unit[9:0]});
              end else begin
                // Unpaired high surrogate: replacement character, then the unit.
                pre_en = 1'b1;
                pre_cp = REPLACE;
                main_e = jsu_pkg::utf8_encode({5'b0, unit});
              end
            end
          end
        end
        M_HSWAIT: begin
          if (in_text_byte == CH_BSL) begin
            mode_nxt = M_HSESC;
          end else begin
            pre_en   = 1'b1;
            run_body = 1'b1;
          end
        end
        M_HSESC: begin
          run_esc = 1'b1;
          if (in_text_byte == CH_U) begin
            esc_hex_mode = M_HEX2;
          end else begin
            pre_en = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
        end
      endcase
    end

    if (run_body) begin
      if (in_text_byte == CH_QUOTE) begin
        done     = 1'b1;
        mode_nxt = M_IDLE;
      end else if (in_text_byte == CH_BSL) begin
        mode_nxt = M_ESC;
      end else begin
        main_e.b[0] = in_text_byte;
        main_e.len  = 3'd1;
        mode_nxt    = M_BODY;
      end
    end

    if (run_esc) begin
      mode_nxt   = M_BODY;
      main_e.len = 3'd1;
      unique case (in_text_byte)
        CH_QUOTE: main_e.b[0] = CH_QUOTE;
        CH_BSL:   main_e.b[0] = CH_BSL;
        CH_SLASH: main_e.b[0] = CH_SLASH;
        CH_B:     main_e.b[0] = 8'h08;
        CH_F:     main_e.b[0] = 8'h0C;
        CH_N:     main_e.b[0] = 8'h0A;
        CH_R:     main_e.b[0] = 8'h0D;
        CH_T:     main_e.b[0] = 8'h09;
        CH_U: begin
          main_e.len  = 3'd0;
          mode_nxt    = esc_hex_mode;
          hex_cnt_nxt = '0;
          accum_nxt   = '0;
        end
        default: begin
          main_e.len = 3'd0;
          err        = jsu_pkg::ERR_BAD_ESC;
          mode_nxt   = M_IDLE;
        end
      endcase
    end

    if (err == jsu_pkg::ERR_NONE && in_end_of_text && mode_nxt != M_IDLE) begin
      err      = (mode_nxt == M_HEX1 || mode_nxt == M_HEX2) ? jsu_pkg::ERR_BAD_HEX
                                                           : jsu_pkg::ERR_UNTERM;
      mode_nxt = M_IDLE;
    end
  end

  // The prefix is always a three-byte form (high surrogate or U+FFFD).
  assign pre_e = jsu_pkg::utf8_encode({5'b0, pre_cp});

  always_comb begin
    pkt      = '0;
    pkt.err  = err;
    if (err == jsu_pkg::ERR_NONE) begin
      pkt.done = done;
      if (pre_en) begin
        pkt.bytes[0] = pre_e.b[0];
        pkt.bytes[1] = pre_e.b[1];
        pkt.bytes[2] = pre_e.b[2];
        pkt.bytes[3] = main_e.b[0];
        pkt.bytes[4] = main_e.b[1];
        pkt.bytes[5] = main_e.b[2];
        pkt.cnt      = 3'd3 + main_e.len;
      end else begin
        pkt.bytes[0] = main_e.b[0];
        pkt.bytes[1] = main_e.b[1];
        pkt.bytes[2] = main_e.b[2];
        pkt.bytes[3] = main_e.b[3];
        pkt.cnt      = main_e.len;
      end
    end
  end

  assign push = accept && (pkt.err != jsu_pkg::ERR_NONE || pkt.cnt != 3'd0 || pkt.done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      hex_cnt_r <= '0;
      accum_r   <= '0;
      hs_r      <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      accum_r   <= accum_nxt;
      hs_r      <= hs_nxt;
    end
  end

endmodule

`default_nettype wire

### design/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue: packet FIFO
// Small register FIFO between the decoder and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: result serializer
// Walks through the packet at the head of the queue and hands out one result
// word per cycle while out_ready holds, marking the last word of each packet.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire jsu_pkg::pkt_t pkt,
  input  wire logic          pkt_valid,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic               out_string_done,
  output logic [1:0]         out_error_code,
  output logic               out_run_last
);

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] n_words;
  logic       last;
  logic       take;

  assign n_words   = (pkt.err != jsu_pkg::ERR_NONE) ? 3'd1 : pkt.cnt + {2'b00, pkt.done};
  assign last      = (idx_r == n_words - 3'd1);
  assign out_valid = pkt_valid;
  assign take      = out_valid && out_ready;
  assign pop       = take && last;

  always_comb begin
    out_byte        = '0;
    out_byte_valid  = 1'b0;
    out_string_done = 1'b0;
    out_error_code  = pkt.err;
    out_run_last    = last;
    if (pkt.err == jsu_pkg::ERR_NONE) begin
      if (idx_r < pkt.cnt) begin
        out_byte       = pkt.bytes[idx_r];
        out_byte_valid = 1'b1;
      end else begin
        out_string_done = 1'b1;
      end
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

### design/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string literal unescaper with UTF-8 output
// Decodes the bytes of a JSON string, escapes and \u units included, into
// the UTF-8 bytes of its value, with done and error reporting.
// ----------------------------------------------------------------------------
// Usage. Text bytes enter on the in_ channel, one word per byte, with a flag
// for the opening quote and one for the end of the text. Each accepted word
// yields zero to six result words on the out_ channel: decoded bytes, then a
// done word on the closing quote, or a single error word instead. The last
// word caused by an input word carries out_run_last.
// The queue registers each packet before the first result of its word is
// offered. Throughput: one input word per cycle while each word yields at
// most one result and the receiver is ready; the k results of a word pass
// the serializer at one word per cycle, which sets the sustained rate.
// A queue of QUEUE_DEPTH packets sits between the decoder and the serializer,
// so input stays open while the receiver stalls until the queue fills; then
// in_ready drops and nothing is lost. A synchronous reset (rst_n low) empties
// the queue and puts the decoder back to waiting for an opening quote; the
// block accepts words in the first cycle after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_opens_string,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_string_done,
  output logic [1:0]      out_error_code,
  output logic            out_run_last
);

  // Packets from the decoder, one per word that has any result.
  jsu_pkg::pkt_t front_pkt;
  jsu_pkg::pkt_t head_pkt;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  jsu_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_opens_string (in_opens_string),
    .in_end_of_text  (in_end_of_text),
    .q_full          (q_full),
    .push            (push),
    .pkt             (front_pkt)
  );

  // The queue stores the packet as a flat vector.
  jsu_queue #(
    .WIDTH ($bits(jsu_pkg::pkt_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_pkt),
    .pop     (pop),
    .rd_data (head_pkt),
    .full    (q_full),
    .empty   (q_empty)
  );

  // The serializer offers words whenever the queue holds a packet.
  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pkt             (head_pkt),
    .pkt_valid       (!q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code),
    .out_run_last    (out_run_last)
  );

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the JSON string unescaper
// Feeds the bytes of JSON string literals, well formed and broken, through
// the valid/ready input channel and compares every result word, field by
// field, against a cycle-free decoder in the bench or hand-typed results.
// Both channels idle and stall at random; the receiver also holds off once
// for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  // --------------------------------------------------------------------------
  // Run length and timing limits.
  // --------------------------------------------------------------------------
  // Text bytes of the random part that the block actually decodes.
  localparam int RANDOM_WORDS   = 290;
  // Cycles of the one long receiver hold-off.
  localparam int LONG_HOLD      = 300;
  // Input words accepted before the long hold-off starts.
  localparam int HOLD_AFTER     = 120;
  // Cycles in a row with no handshake on either side before giving up. The
  // longest legal quiet stretch is the long hold-off; this is ten times that.
  localparam int WATCHDOG_LIMIT = 3000;
  // Settling time once nothing is expected any more, so that a stray result
  // word that the block still offers is caught by the output check.
  localparam int DRAIN_CYCLES   = 16;

  // --------------------------------------------------------------------------
  // Character codes of the JSON text.
  // --------------------------------------------------------------------------
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  // Bytes that the single-letter escapes stand for.
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  // UTF-16 surrogate ranges and the replacement character.
  localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
  localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] SURR_END        = 16'hE000;
  localparam logic [20:0] CP_REPLACEMENT  = 21'h00FFFD;
  localparam logic [20:0] CP_SUPPLEMENT   = 21'h010000;

  localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                            CH_F, CH_N, CH_R, CH_T};

  // --------------------------------------------------------------------------
  // Types.
  // --------------------------------------------------------------------------
  // Where a stimulus word gets its expected results: from the decoder model,
  // or typed in by hand (no result, one error word, one plain byte).
  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_ERROR, ROW_PLAIN} row_kind_t;

  typedef struct packed {
    logic [7:0] text;
    logic       opens;
    logic       eot;
    row_kind_t  kind;
    logic [7:0] value;
  } stim_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       closed;
    logic [1:0] fault;
    logic       last;
  } result_t;

  // Decoder states of the model kept in the bench.
  typedef enum logic [3:0] {
    DM_IDLE, DM_BODY, DM_ESC, DM_HEX1, DM_HSWAIT, DM_HSESC, DM_HEX2
  } dec_mode_t;

  // --------------------------------------------------------------------------
  // Directed words. The expected results are typed in where they are plain
  // to see; the surrogate pair and the closing quote go to the decoder model.
  // --------------------------------------------------------------------------
  localparam int DIRECTED_COUNT = 28;
  localparam stim_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // A stray byte right after reset is ignored.
    '{8'h41,       1'b0, 1'b0, ROW_NONE,    8'h00},
    // Opening quote of any value, then the two byte extremes pass through.
    '{8'h00,       1'b1, 1'b0, ROW_NONE,    8'h00},
    '{8'h00,       1'b0, 1'b0, ROW_PLAIN,   8'h00},
    '{8'hFF,       1'b0, 1'b0, ROW_PLAIN,   8'hFF},
    // \uDBfF\udffF: the highest code point, U+10FFFF, in four bytes.
    '{CH_BSLASH,   1'b0, 1'b0, ROW_NONE,    8'h00},
    '{CH_U,        1'b0, 1'b0, ROW_NONE,    8'h00},
    '{8'h44,       1'b0, 1'b0, ROW_NONE,    8'h00},
    '{8'h42,       1'b0, 1'b0, ROW_NONE,    8'h00},
    '{8'h66,       1'b0, 1'b0, ROW_NONE,    8'h00},
    '{8'h46,       1'b0, 1'b0, ROW_NONE,    8'h00},
    '{CH_BSLASH,   1'b0, 1'b0, ROW_NONE,    8'h00},
    '{CH_U,        1'b0, 1'b0, ROW_NONE,    8'h00},
    '{8'h64,       1'b0, 1'b0, ROW_NONE,    8'h00},
    '{8'h66,       1'b0, 1'b0, ROW_NONE,    8'h00},
    '{8'h66,       1'b0, 1'b0, ROW_NONE,    8'h00},
    '{8'h46,       1'b0, 1'b0, ROW_PREDICT, 8'h00},
    '{CH_QUOTE,    1'b0, 1'b0, ROW_PREDICT, 8'h00},
    // A byte that is no hex digit inside \u.
    '{CH_QUOTE,    1'b1, 1'b0, ROW_NONE,    8'h00},
    '{CH_BSLASH,   1'b0, 1'b0, ROW_NONE,    8'h00},
    '{CH_U,        1'b0, 1'b0, ROW_NONE,    8'h00},
    '{8'h67,       1'b0, 1'b0, ROW_ERROR,   8'(jsu_pkg::ERR_BAD_HEX)},
    // A new opening quote in the middle of an escape drops the old string,
    // and an unknown escape letter follows.
    '{8'hFF,       1'b1, 1'b0, ROW_NONE,    8'h00},
    '{CH_BSLASH,   1'b0, 1'b0, ROW_NONE,    8'h00},
    '{CH_QUOTE,    1'b1, 1'b0, ROW_NONE,    8'h00},
    '{CH_BSLASH,   1'b0, 1'b0, ROW_NONE,    8'h00},
    '{8'h71,       1'b0, 1'b0, ROW_ERROR,   8'(jsu_pkg::ERR_BAD_ESC)},
    // The text ends with the string still open; the plain byte is dropped.
    '{CH_QUOTE,    1'b1, 1'b0, ROW_NONE,    8'h00},
    '{8'h61,       1'b0, 1'b1, ROW_ERROR,   8'(jsu_pkg::ERR_UNTERM)}
  };

  // --------------------------------------------------------------------------
  // Signals.
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_opens_string = 1'b0;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_string_done;
  logic [1:0] out_error_code;
  logic       out_run_last;

  // How the word now on the input channel is to be checked; it changes in
  // the same step as the payload, so it always belongs to that word.
  row_kind_t  row_kind = ROW_PREDICT;
  logic [7:0] row_value = 8'h00;

  json_string_unescape_utf8 dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_opens_string (in_opens_string),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code),
    .out_run_last    (out_run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model. unescape_step takes one accepted text byte and leaves the
  // result words it causes in step_results.
  // --------------------------------------------------------------------------
  dec_mode_t   dec_mode = DM_IDLE;
  logic [1:0]  hex_cnt = '0;
  logic [15:0] unit_acc = '0;
  logic [15:0] hi_unit = '0;

  logic [7:0]  step_bytes [$];
  logic        step_closed;
  logic [1:0]  step_fault;
  result_t     step_results [$];

  // Expected result words, oldest first.
  result_t     decoded_q [$];

  int          mismatches = 0;
  int          words_in = 0;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  // Appends one decoded byte to the bytes of the current step.
  function automatic void add_byte(input logic [7:0] b);
    step_bytes.insert(step_bytes.size(), b);
  endfunction

  // Appends one result word to the words of the current step.
  function automatic void queue_result(input result_t r);
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic void emit_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void raise_fault(input logic [1:0] code);
    step_fault = code;
    dec_mode = DM_IDLE;
  endfunction

  function automatic void take_body(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      step_closed = 1'b1;
      dec_mode = DM_IDLE;
    end else if (c == CH_BSLASH) begin
      dec_mode = DM_ESC;
    end else begin
      add_byte(c);
      dec_mode = DM_BODY;
    end
  endfunction

  function automatic void take_escape(input logic [7:0] e, input dec_mode_t hex_mode);
    dec_mode = DM_BODY;
    case (e) inside
      CH_QUOTE, CH_BSLASH, CH_SLASH: add_byte(e);
      CH_B: add_byte(CTL_BS);
      CH_F: add_byte(CTL_FF);
      CH_N: add_byte(CTL_LF);
      CH_R: add_byte(CTL_CR);
      CH_T: add_byte(CTL_TAB);
      CH_U: begin
        dec_mode = hex_mode;
        hex_cnt = '0;
        unit_acc = '0;
      end
      default: raise_fault(jsu_pkg::ERR_BAD_ESC);
    endcase
  endfunction

  function automatic void take_hex(input logic [7:0] c);
    int d;
    logic [15:0] u;
    d = nibble_of(c);
    if (d < 0) begin
      raise_fault(jsu_pkg::ERR_BAD_HEX);
      return;
    end
    unit_acc = {unit_acc[11:0], 4'(d)};
    if (hex_cnt != 2'd3) begin
      hex_cnt = hex_cnt + 2'd1;
      return;
    end
    hex_cnt = '0;
    u = unit_acc;
    if (dec_mode == DM_HEX1) begin
      if (u >= SURR_HIGH_FIRST && u < SURR_LOW_FIRST) begin
        hi_unit = u;
        dec_mode = DM_HSWAIT;
      end else begin
        emit_cp({5'b0, u});
        dec_mode = DM_BODY;
      end
    end else begin
      // The second \u of a pair. hi_unit is a high surrogate here, so its
      // offset from D800 is just its low ten bits; the same holds for u.
      if (u >= SURR_LOW_FIRST && u < SURR_END) begin
        emit_cp(CP_SUPPLEMENT + 21'({hi_unit[9:0], u[9:0]}));
      end else begin
        emit_cp(CP_REPLACEMENT);
        emit_cp({5'b0, u});
      end
      dec_mode = DM_BODY;
    end
  endfunction

  task automatic unescape_step(input logic [7:0] c, input logic opens, input logic eot);
    step_bytes.delete();
    step_results.delete();
    step_closed = 1'b0;
    step_fault = jsu_pkg::ERR_NONE;
    // Outside a string only an opening quote matters.
    if (!opens && dec_mode == DM_IDLE) return;
    if (opens) begin
      dec_mode = DM_BODY;
      hex_cnt = '0;
      unit_acc = '0;
      hi_unit = '0;
    end else begin
      case (dec_mode) inside
        DM_BODY: take_body(c);
        DM_ESC: take_escape(c, DM_HEX1);
        DM_HEX1, DM_HEX2: take_hex(c);
        DM_HSWAIT: begin
          if (c == CH_BSLASH) begin
            dec_mode = DM_HSESC;
          end else begin
            emit_cp({5'b0, hi_unit});
            take_body(c);
          end
        end
        DM_HSESC: begin
          if (c == CH_U) begin
            take_escape(c, DM_HEX2);
          end else begin
            emit_cp({5'b0, hi_unit});
            take_escape(c, DM_HEX1);
          end
        end
        default: dec_mode = DM_IDLE;
      endcase
    end
    if (step_fault == jsu_pkg::ERR_NONE && eot && dec_mode != DM_IDLE) begin
      raise_fault((dec_mode == DM_HEX1 || dec_mode == DM_HEX2) ? jsu_pkg::ERR_BAD_HEX
                                                               : jsu_pkg::ERR_UNTERM);
    end
    // An error word replaces anything decoded earlier in the same step.
    if (step_fault != jsu_pkg::ERR_NONE) begin
      queue_result(result_t'{data: 8'h00, has_byte: 1'b0, closed: 1'b0,
                             fault: step_fault, last: 1'b1});
      return;
    end
    foreach (step_bytes[k]) begin
      if (k < jsu_pkg::PKT_BYTES) begin
        queue_result(result_t'{data: step_bytes[k], has_byte: 1'b1, closed: 1'b0,
                               fault: jsu_pkg::ERR_NONE, last: 1'b0});
      end
    end
    if (step_closed && step_results.size() < jsu_pkg::PKT_BYTES) begin
      queue_result(result_t'{data: 8'h00, has_byte: 1'b0, closed: 1'b1,
                             fault: jsu_pkg::ERR_NONE, last: 1'b0});
    end
    if (step_results.size() != 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side: every accepted word updates the model, and its results are
  // queued, unless the row carries its own hand-typed expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      words_in++;
      unescape_step(in_text_byte, in_opens_string, in_end_of_text);
      case (row_kind)
        ROW_NONE: step_results.delete();
        ROW_ERROR: begin
          step_results.delete();
          queue_result(result_t'{data: 8'h00, has_byte: 1'b0, closed: 1'b0,
                                 fault: row_value[1:0], last: 1'b1});
        end
        ROW_PLAIN: begin
          step_results.delete();
          queue_result(result_t'{data: row_value, has_byte: 1'b1, closed: 1'b0,
                                 fault: jsu_pkg::ERR_NONE, last: 1'b1});
        end
        default: ;
      endcase
      foreach (step_results[k]) decoded_q.insert(decoded_q.size(), step_results[k]);
    end
  end

  // --------------------------------------------------------------------------
  // Output side: each accepted result word is checked against the oldest
  // expected word.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result word: byte %0h, done %0b, error %0d",
               out_byte, out_string_done, out_error_code);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("out_byte_valid", 8'(want.has_byte), 8'(out_byte_valid));
        check_field("out_string_done", 8'(want.closed), 8'(out_string_done));
        check_field("out_error_code", 8'(want.fault), 8'(out_error_code));
        check_field("out_run_last", 8'(want.last), 8'(out_run_last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then long.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver. Random stalls, runs of steady readiness, and one long hold-off
  // once the input side is well under way, so that the internal queue fills
  // and in_ready has to drop while the sender keeps offering words.
  initial begin
    int gap;
    bit held_off;
    held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && words_in >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b1;
        repeat (40) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: a run of cycles with no handshake on either channel means the
  // block has hung.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet = 0;
      else quiet++;
    end
    $display("[json_string_unescape_utf8] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus building.
  // --------------------------------------------------------------------------
  stim_t stim_q [$];
  bit    steady_sender = 1'b0;

  task automatic add_word(input logic [7:0] text, input logic opens, input logic eot);
    stim_q.insert(stim_q.size(), stim_t'{text: text, opens: opens, eot: eot,
                                         kind: ROW_PREDICT, value: 8'h00});
  endtask

  // Hex digits a to f come in either case.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_0 + 8'(n);
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(n - 4'd10);
  endfunction

  task automatic add_digits(input logic [15:0] u, input int count);
    for (int i = 3; i > 3 - count; i--) add_word(hex_char(u[i*4 +: 4]), 1'b0, 1'b0);
  endtask

  task automatic add_unit(input logic [15:0] u);
    add_word(CH_BSLASH, 1'b0, 1'b0);
    add_word(CH_U, 1'b0, 1'b0);
    add_digits(u, 4);
  endtask

  function automatic logic [15:0] pick_unit();
    logic [15:0] edges [10];
    edges = '{16'h0000, 16'hFFFF, 16'h007F, 16'h0080, 16'h07FF,
              16'h0800, 16'hD800, 16'hDBFF, 16'hDC00, 16'hDFFF};
    case ($urandom_range(0, 6))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hD7FF));
      3: return 16'($urandom_range(16'hE000, 16'hFFFF));
      4: return 16'($urandom_range(16'hD800, 16'hDBFF));
      5: return 16'($urandom_range(16'hDC00, 16'hDFFF));
      default: return edges[$urandom_range(0, 9)];
    endcase
  endfunction

  function automatic bit escape_letter(input logic [7:0] c);
    foreach (SIMPLE_ESC[k]) if (c == SIMPLE_ESC[k]) return 1'b1;
    return c == CH_U;
  endfunction

  // One piece of a string body.
  task automatic add_element();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // Any byte but the two that the decoder treats specially.
      b = 8'($urandom_range(0, 255));
      if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
      add_word(b, 1'b0, 1'b0);
    end else if (r < 50) begin
      add_word(CH_BSLASH, 1'b0, 1'b0);
      add_word(SIMPLE_ESC[$urandom_range(0, 7)], 1'b0, 1'b0);
    end else if (r < 75) begin
      add_unit(pick_unit());
    end else if (r < 90) begin
      add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
      add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
    end else begin
      // A high surrogate followed by a unit of any kind, often not a low one.
      add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
      add_unit(pick_unit());
    end
  endtask

  // One string: opening quote, a short body, then a closing quote or one of
  // the ways a string can go wrong. Returns 1 if the decoder ends up idle.
  task automatic build_string(output bit ended);
    int len;
    int r;
    int k;
    logic [7:0] b;
    ended = 1'b1;
    add_word($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : CH_QUOTE, 1'b1, 1'b0);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
    repeat (len) add_element();
    r = $urandom_range(0, 99);
    if (r < 60) begin
      add_word(CH_QUOTE, 1'b0, $urandom_range(0, 7) == 0);
    end else if (r < 68) begin
      do b = 8'($urandom_range(0, 255)); while (escape_letter(b));
      add_word(CH_BSLASH, 1'b0, 1'b0);
      add_word(b, 1'b0, 1'b0);
    end else if (r < 76) begin
      do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
      add_word(CH_BSLASH, 1'b0, 1'b0);
      add_word(CH_U, 1'b0, 1'b0);
      add_digits(pick_unit(), $urandom_range(0, 3));
      add_word(b, 1'b0, 1'b0);
    end else if (r < 88) begin
      // The text runs out inside the string: after a plain byte, a lone
      // backslash, part of a \u escape, or a pending high surrogate.
      k = $urandom_range(0, 3);
      case (k)
        0: add_word(8'($urandom_range(0, 255)) & 8'h7F | 8'h40, 1'b0, 1'b0);
        1: add_word(CH_BSLASH, 1'b0, 1'b0);
        2: begin
          add_word(CH_BSLASH, 1'b0, 1'b0);
          add_word(CH_U, 1'b0, 1'b0);
          add_digits(pick_unit(), $urandom_range(0, 3));
        end
        default: add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
      endcase
      stim_q[stim_q.size() - 1].eot = 1'b1;
    end else begin
      // Left open: the next opening quote abandons it.
      ended = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender.
  // --------------------------------------------------------------------------
  task automatic send_words();
    stim_t w;
    int gap;
    while (stim_q.size() != 0) begin
      w = stim_q.pop_front();
      gap = steady_sender ? 0 : pick_gap();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid        <= 1'b1;
      in_text_byte    <= w.text;
      in_opens_string <= w.opens;
      in_end_of_text  <= w.eot;
      row_kind        <= w.kind;
      row_value       <= w.value;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
  endtask

  // Stop offering words until every expected word has come out. The extra
  // edge lets the input monitor queue the results of the last word first.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int random_words;
    bit mid_pause_done;
    bit ended;
    random_words = 0;
    mid_pause_done = 1'b0;

    // Reset held low at the start, once.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    foreach (DIRECTED_ROWS[k]) stim_q.insert(stim_q.size(), DIRECTED_ROWS[k]);
    send_words();
    wait_all_results();

    // Random part: whole strings with random content, noise between them.
    while (random_words < RANDOM_WORDS) begin
      if (!mid_pause_done && random_words >= RANDOM_WORDS / 2) begin
        mid_pause_done = 1'b1;
        wait_all_results();
      end
      steady_sender = ($urandom_range(0, 4) == 0);
      build_string(ended);
      random_words += stim_q.size();
      // Bytes between strings are ignored by the block and do not count.
      if (ended && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          add_word(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 1));
        end
      end
      send_words();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[json_string_unescape_utf8] OK");
    end else begin
      $display("[json_string_unescape_utf8] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
